// ----- rtl/ubo_pkg.sv -----
package ubo_pkg;

    typedef logic [20:0] cp_t;

    // One decoded code point with its byte sequence and break decisions
    typedef struct packed {
        logic [3:0][7:0] bytes;     // bytes[0] is the lead byte
        logic [2:0]      cnt;       // bytes present, 1 to 4
        logic            pre_zw;    // zero-width space before the bytes
        logic            post_zw;   // zero-width space after the bytes
        logic            str_end;   // last code point of the string
    } cp_rec_t;

    localparam logic [7:0] ZW_B0 = 8'hE2;
    localparam logic [7:0] ZW_B1 = 8'h80;
    localparam logic [7:0] ZW_B2 = 8'h8B;

    localparam cp_t CP_HONORIFIC_O  = 21'h0304A;
    localparam cp_t CP_HONORIFIC_GO = 21'h03054;
    localparam cp_t CP_IDEO_COMMA   = 21'h03001;
    localparam cp_t CP_IDEO_STOP    = 21'h03002;
    localparam cp_t CP_KATA_DOT     = 21'h030FB;
    localparam cp_t CP_FW_EXCL      = 21'h0FF01;
    localparam cp_t CP_FW_COLON     = 21'h0FF1A;
    localparam cp_t CP_FW_QUEST     = 21'h0FF1F;
    localparam cp_t CP_KANJI_LO     = 21'h04E00;
    localparam cp_t CP_KANJI_HI     = 21'h09FFF;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        if (!b[7]) begin
            len = 3'd1;
        end else if (b[7:5] == 3'b110) begin
            len = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            len = 3'd3;
        end else begin
            len = 3'd4;
        end
        return len;
    endfunction

    function automatic logic is_punct(input cp_t cp);
        return cp == CP_IDEO_COMMA || cp == CP_IDEO_STOP || cp == CP_KATA_DOT ||
               cp == CP_FW_EXCL || cp == CP_FW_COLON || cp == CP_FW_QUEST;
    endfunction

    function automatic logic is_kana(input cp_t cp);
        return (cp >= 21'h03041 && cp <= 21'h03096) ||
               (cp >= 21'h030A1 && cp <= 21'h030FC) ||
               (cp >= 21'h0FF66 && cp <= 21'h0FF9D);
    endfunction

    function automatic logic is_kanji(input cp_t cp);
        return cp >= CP_KANJI_LO && cp <= CP_KANJI_HI;
    endfunction

    function automatic logic is_latin(input cp_t cp);
        return (cp >= 21'h30 && cp <= 21'h39) || (cp >= 21'h41 && cp <= 21'h5A) ||
               (cp >= 21'h61 && cp <= 21'h7A);
    endfunction

    // Break after cp (preceded by prev) when ncp follows
    function automatic logic break_between(input cp_t cp, input cp_t prev, input cp_t ncp,
                                           input logic next_zw);
        logic brk;
        brk = 1'b0;
        if (!next_zw) begin
            if (is_punct(cp)) begin
                brk = 1'b1;
            end
            if (is_kana(cp) && cp != CP_HONORIFIC_O && cp != CP_HONORIFIC_GO &&
                !is_kanji(prev) && is_kanji(ncp)) begin
                brk = 1'b1;
            end
            if (is_latin(cp) && (is_kana(ncp) || is_kanji(ncp))) begin
                brk = 1'b1;
            end
            if ((is_kana(cp) || is_kanji(cp)) && is_latin(ncp)) begin
                brk = 1'b1;
            end
        end
        return brk;
    endfunction

endpackage

// ----- rtl/ubo_front.sv -----
module ubo_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] in_byte
    input  logic              s_tlast,   // string_end
    input  logic              q_full,
    output logic              q_push,
    output ubo_pkg::cp_rec_t  q_rec
);
    import ubo_pkg::*;

    logic [7:0] pending_reg [3];
    logic [1:0] held_reg, held_next;
    logic [2:0] exp_reg, exp_next;
    cp_t        held_cp_reg, held_cp_next;
    cp_t        prev_cp_reg, prev_cp_next;
    logic       have_reg, have_next;

    logic            accept;
    logic [2:0]      exp_cur;
    logic [2:0]      n_now;
    logic            complete;
    logic [3:0][7:0] c;
    cp_t             cp;
    logic            zw;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        exp_cur  = (held_reg == 2'd0) ? lead_len(s_tdata) : exp_reg;
        n_now    = {1'b0, held_reg} + 3'd1;
        complete = (n_now >= exp_cur) || s_tlast;
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < held_reg) begin
                c[i] = pending_reg[i];
            end else if (2'(i) == held_reg) begin
                c[i] = s_tdata;
            end else begin
                c[i] = 8'h00;
            end
        end
        c[3] = (held_reg == 2'd3) ? s_tdata : 8'h00;

        unique case (exp_cur)
            3'd1:    cp = {13'd0, c[0]};
            3'd2:    cp = {10'd0, c[0][4:0], c[1][5:0]};
            3'd3:    cp = {5'd0, c[0][3:0], c[1][5:0], c[2][5:0]};
            default: cp = {c[0][2:0], c[1][5:0], c[2][5:0], c[3][5:0]};
        endcase
        zw = (n_now == 3'd3) && c[0] == ZW_B0 && c[1] == ZW_B1 && c[2] == ZW_B2;

        q_push        = accept && complete;
        q_rec.bytes   = c;
        q_rec.cnt     = n_now;
        q_rec.pre_zw  = have_reg && break_between(held_cp_reg, prev_cp_reg, cp, zw);
        q_rec.post_zw = s_tlast && is_punct(cp);
        q_rec.str_end = s_tlast;
    end

    always_comb begin
        held_next    = held_reg;
        exp_next     = exp_reg;
        held_cp_next = held_cp_reg;
        prev_cp_next = prev_cp_reg;
        have_next    = have_reg;
        if (accept) begin
            exp_next  = exp_cur;
            held_next = complete ? 2'd0 : held_reg + 2'd1;
            if (complete) begin
                if (s_tlast) begin
                    held_cp_next = '0;
                    prev_cp_next = '0;
                    have_next    = 1'b0;
                end else begin
                    prev_cp_next = have_reg ? held_cp_reg : '0;
                    held_cp_next = cp;
                    have_next    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg    <= '0;
            exp_reg     <= '0;
            held_cp_reg <= '0;
            prev_cp_reg <= '0;
            have_reg    <= 1'b0;
        end else begin
            held_reg    <= held_next;
            exp_reg     <= exp_next;
            held_cp_reg <= held_cp_next;
            prev_cp_reg <= prev_cp_next;
            have_reg    <= have_next;
        end
    end

    // Only bytes of an unfinished sequence are stored
    always_ff @(posedge aclk) begin
        if (accept && !complete) begin
            pending_reg[held_reg] <= s_tdata;
        end
    end

    a_prev_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !have_reg |-> (prev_cp_reg == '0 && held_cp_reg == '0))
        else $error("history kept with nothing held");
    a_full_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (held_reg == 2'd3) |-> (exp_reg == 3'd4))
        else $error("three bytes gathered for a short sequence");
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("push into a full queue");

endmodule

// ----- rtl/ubo_queue.sv -----
module ubo_queue #(
    parameter int DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  ubo_pkg::cp_rec_t  push_rec,
    output logic              full,
    input  logic              pop,
    output logic              q_valid,
    output ubo_pkg::cp_rec_t  pop_rec
);
    import ubo_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cp_rec_t         mem_reg [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign pop_rec = mem_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push) begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_rec;
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");
    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (wr_reg == rd_reg))
        else $error("pointers differ on empty queue");
    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && !do_push) |=> (cnt_reg == $past(cnt_reg) - CW'(1)))
        else $error("pop did not drain one entry");

endmodule

// ----- rtl/ubo_back.sv -----
module ubo_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  ubo_pkg::cp_rec_t  q_rec,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] out_byte
    output logic              m_tlast,   // run_last
    output logic              m_tuser    // string_done
);
    import ubo_pkg::*;

    typedef enum logic [1:0] {PH_PRE, PH_DATA, PH_POST} phase_t;

    cp_rec_t    cur_reg;
    logic       cur_valid_reg;
    phase_t     phase_reg;
    logic [1:0] idx_reg;
    logic       m_valid_reg;
    logic [7:0] m_data_reg;
    logic       m_last_reg;
    logic       m_user_reg;

    logic       can_out;
    logic       emit;
    logic       last;
    logic [7:0] byte_out;
    phase_t     phase_adv;
    logic [1:0] idx_adv;
    logic [7:0] zw_byte;

    always_comb begin
        unique case (idx_reg)
            2'd0:    zw_byte = ZW_B0;
            2'd1:    zw_byte = ZW_B1;
            default: zw_byte = ZW_B2;
        endcase
    end

    always_comb begin
        can_out   = !m_valid_reg || m_tready;
        emit      = cur_valid_reg && can_out;
        last      = 1'b0;
        phase_adv = phase_reg;
        idx_adv   = idx_reg + 2'd1;
        byte_out  = zw_byte;
        unique case (phase_reg)
            PH_PRE: begin
                if (idx_reg == 2'd2) begin
                    phase_adv = PH_DATA;
                    idx_adv   = 2'd0;
                end
            end
            PH_DATA: begin
                byte_out = cur_reg.bytes[idx_reg];
                if ({1'b0, idx_reg} == cur_reg.cnt - 3'd1) begin
                    if (cur_reg.post_zw) begin
                        phase_adv = PH_POST;
                        idx_adv   = 2'd0;
                    end else begin
                        last = 1'b1;
                    end
                end
            end
            default: begin
                last = (idx_reg == 2'd2);
            end
        endcase
        q_pop = q_valid && (!cur_valid_reg || (emit && last));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            phase_reg     <= PH_PRE;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (q_pop) begin
                cur_valid_reg <= 1'b1;
                cur_reg       <= q_rec;
                phase_reg     <= q_rec.pre_zw ? PH_PRE : PH_DATA;
                idx_reg       <= '0;
            end else if (emit) begin
                if (last) begin
                    cur_valid_reg <= 1'b0;
                end
                phase_reg <= phase_adv;
                idx_reg   <= idx_adv;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= byte_out;
                m_last_reg  <= last;
                m_user_reg  <= last && cur_reg.str_end;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_user_reg) |-> m_last_reg)
        else $error("string end without run end");
    a_pop_only_free: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (!cur_valid_reg || (emit && last)))
        else $error("record loaded over one in progress");
    a_data_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_valid_reg && phase_reg == PH_DATA) |-> ({1'b0, idx_reg} < cur_reg.cnt))
        else $error("byte index past sequence length");
    a_post_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_valid_reg && phase_reg == PH_POST) |-> cur_reg.str_end)
        else $error("trailing space away from string end");

endmodule

// ----- rtl/utf8_break_opportunity_inserter.sv -----
// UTF-8 break opportunity inserter. Bytes of a string enter on the s_ channel (s_tlast marks
// the final byte of a string) and leave unchanged on the m_ channel, with the zero-width
// space E2 80 8B inserted after a code point where a line break is allowed; m_tlast marks
// the last output byte caused by one input code point and m_tuser the last byte of a string.
// The front gathers and decodes a code point and makes the break decision in the cycle
// its final byte is accepted; a queue of QUEUE_DEPTH code points separates it from the
// back, which sends one output byte per cycle while m_tready is high, through a registered
// output. An input byte is accepted in every cycle the queue has room, so throughput is
// set by the output: each code point costs its own bytes plus three bytes for every
// inserted space. The queue entry, the current-record register and the output register
// lie between the final byte of a code point and its first output byte.
module utf8_break_opportunity_inserter #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // string_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // run_last
    output logic       m_tuser    // string_done
);
    import ubo_pkg::*;

    cp_rec_t push_rec;
    cp_rec_t pop_rec;
    logic    push;
    logic    full;
    logic    pop;
    logic    q_valid;

    ubo_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (full),
        .q_push   (push),
        .q_rec    (push_rec)
    );

    ubo_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .full     (full),
        .pop      (pop),
        .q_valid  (q_valid),
        .pop_rec  (pop_rec)
    );

    ubo_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_rec    (pop_rec),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
